>>> src/csort_pkg.sv
package csort_pkg;

   // Field widths fixed by the word format
   localparam int KEY_W   = 7;
   localparam int COUNT_W = 7;

   // Shared adder operations
   typedef logic [1:0] alu_op_type;
   localparam alu_op_type ALU_INC = 2'd0;
   localparam alu_op_type ALU_ADD = 2'd1;
   localparam alu_op_type ALU_DEC = 2'd2;

   typedef struct packed {
      alu_op_type         op;
      logic [COUNT_W-1:0] a;
      logic [COUNT_W-1:0] b;
   } alu_req_type;

endpackage

>>> src/csort_ram.sv
module csort_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 7,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read; hold the last word while idle
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/csort_alu.sv
module csort_alu (
   input  csort_pkg::alu_req_type            req,
   output logic [csort_pkg::COUNT_W-1:0]     result
);
   import csort_pkg::*;

   always_comb begin
      case (req.op)
         ALU_INC: result = req.a + COUNT_W'(1);
         ALU_ADD: result = req.a + req.b;
         ALU_DEC: result = req.a - COUNT_W'(1);
         default: result = req.a;
      endcase
   end

endmodule

>>> src/counting_sort_engine_top.sv
// A key is accepted, then its count is updated (S_INC); busy is high during the update.
// After the set-end key of a non-empty set: one count pass, then each held key is fetched,
// its running sum fetched and the key placed; then one result per cycle, the first result
// the cycle after emit starts. Then a clear pass runs before the next key is taken.
// Reset (synchronous, active high) starts the same clear pass; busy stays high through it.
// The receiver cannot stall: each result is shown for exactly one cycle on rsp_valid.
module counting_sort_engine_top #(
   parameter int NUM_KEYS  = 128,
   parameter int MAX_ITEMS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [csort_pkg::KEY_W-1:0]   req_key_value,
   input  logic                          req_set_end,
   output logic                          rsp_valid,
   output logic [csort_pkg::KEY_W-1:0]   rsp_sorted_key,
   output logic                          rsp_final_key,
   output logic                          rsp_overflow_seen
);
   import csort_pkg::*;

   // Keys are only 7 bits wide, so at most 128 count entries can ever be touched
   localparam int CNT_DEPTH = (NUM_KEYS < 128) ? NUM_KEYS : 128;
   localparam int CA_W      = $clog2(CNT_DEPTH);
   localparam int PTR_W     = CA_W + 1;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // zero the count table, one entry a cycle
   localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a key word
   localparam logic [2:0] S_INC   = 3'd2;  // write back count + 1
   localparam logic [2:0] S_PSUM  = 3'd3;  // running sums over the count table
   localparam logic [2:0] S_PKEY  = 3'd4;  // fetch held key
   localparam logic [2:0] S_PCNT  = 3'd5;  // fetch its running sum
   localparam logic [2:0] S_PWR   = 3'd6;  // lower sum, place key
   localparam logic [2:0] S_EMIT  = 3'd7;  // read sorted keys out in order

   logic [2:0]         state_ff, state_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [CA_W-1:0]    waddr_ff, waddr_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0]   held_ff, held_in;
   logic               drop_ff, drop_in;
   logic               last_ff, last_in;
   logic               take_ff, take_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic               valid_ff, valid_in;
   logic               final_ff, final_in;
   logic               ovf_ff, ovf_in;

   // Memory ports
   logic               cnt_we, cnt_re;
   logic [CA_W-1:0]    cnt_waddr, cnt_raddr;
   logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
   logic               held_we, held_re;
   logic [IDX_W-1:0]   held_waddr, held_raddr;
   logic [KEY_W-1:0]   held_rdata;
   logic               sort_we, sort_re;
   logic [IDX_W-1:0]   sort_waddr, sort_raddr;
   logic [KEY_W-1:0]   sort_rdata;

   alu_req_type        alu_req;
   logic [COUNT_W-1:0] alu_result;

   logic               accept;
   logic               key_ok;
   logic               room;
   logic               issue;
   logic [CNT_W-1:0]   walk_dec;
   logic [CNT_W-1:0]   walk_inc;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign key_ok   = (32'(req_key_value) < NUM_KEYS);
   assign room     = (held_ff < CNT_W'(MAX_ITEMS));
   assign issue    = (ptr_ff < PTR_W'(CNT_DEPTH));
   assign walk_dec = walk_ff - CNT_W'(1);
   assign walk_inc = walk_ff + CNT_W'(1);

   csort_ram #(.DEPTH(CNT_DEPTH), .WIDTH(COUNT_W)) u_count_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .re    (cnt_re),
      .raddr (cnt_raddr),
      .rdata (cnt_rdata)
   );

   csort_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_held_ram (
      .clock (clock),
      .we    (held_we),
      .waddr (held_waddr),
      .wdata (req_key_value),
      .re    (held_re),
      .raddr (held_raddr),
      .rdata (held_rdata)
   );

   csort_ram #(.DEPTH(MAX_ITEMS), .WIDTH(KEY_W)) u_sorted_ram (
      .clock (clock),
      .we    (sort_we),
      .waddr (sort_waddr),
      .wdata (key_ff),
      .re    (sort_re),
      .raddr (sort_raddr),
      .rdata (sort_rdata)
   );

   // One adder serves increment, running sum and decrement
   csort_alu u_alu (
      .req    (alu_req),
      .result (alu_result)
   );

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      pend_in   = 1'b0;
      waddr_in  = waddr_ff;
      acc_in    = acc_ff;
      held_in   = held_ff;
      drop_in   = drop_ff;
      last_in   = last_ff;
      take_in   = take_ff;
      key_in    = key_ff;
      walk_in   = walk_ff;
      valid_in  = 1'b0;
      final_in  = 1'b0;
      ovf_in    = ovf_ff;

      cnt_we     = 1'b0;
      cnt_waddr  = key_ff[CA_W-1:0];
      cnt_wdata  = alu_result;
      cnt_re     = 1'b0;
      cnt_raddr  = req_key_value[CA_W-1:0];
      held_we    = 1'b0;
      held_waddr = held_ff[IDX_W-1:0];
      held_re    = 1'b0;
      held_raddr = walk_dec[IDX_W-1:0];
      sort_we    = 1'b0;
      sort_waddr = alu_result[IDX_W-1:0];
      sort_re    = 1'b0;
      sort_raddr = walk_ff[IDX_W-1:0];

      alu_req.op = ALU_INC;
      alu_req.a  = cnt_rdata;
      alu_req.b  = acc_ff;

      case (state_ff)
         S_CLEAR: begin
            // Drop the previous set: zero one count entry per cycle
            cnt_we    = 1'b1;
            cnt_waddr = ptr_ff[CA_W-1:0];
            cnt_wdata = '0;
            ptr_in    = ptr_ff + PTR_W'(1);
            held_in   = '0;
            drop_in   = 1'b0;
            if (ptr_ff == PTR_W'(CNT_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               // Store the key and start the count read; out-of-range keys are ignored
               take_in = key_ok && room;
               last_in = req_set_end;
               key_in  = req_key_value;
               cnt_re  = 1'b1;
               if (key_ok && room) begin
                  held_we = 1'b1;
                  held_in = held_ff + CNT_W'(1);
               end
               if (key_ok && !room) begin
                  drop_in = 1'b1;
               end
               state_in = S_INC;
            end
         end
         S_INC: begin
            if (take_ff) begin
               cnt_we = 1'b1;
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (held_ff == '0) begin
               // Empty set: no results, just clear
               ptr_in   = '0;
               state_in = S_CLEAR;
            end else begin
               ptr_in   = '0;
               acc_in   = '0;
               state_in = S_PSUM;
            end
         end
         S_PSUM: begin
            // Read entry k while entry k-1 gets its running sum
            cnt_re    = issue;
            cnt_raddr = ptr_ff[CA_W-1:0];
            waddr_in  = ptr_ff[CA_W-1:0];
            pend_in   = issue;
            if (issue) begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
            alu_req.op = ALU_ADD;
            alu_req.a  = acc_ff;
            alu_req.b  = cnt_rdata;
            if (pend_ff) begin
               acc_in    = alu_result;
               cnt_we    = 1'b1;
               cnt_waddr = waddr_ff;
            end
            if (!issue) begin
               walk_in  = held_ff;
               state_in = S_PKEY;
            end
         end
         S_PKEY: begin
            // Walk held keys from last to first
            held_re  = 1'b1;
            state_in = S_PCNT;
         end
         S_PCNT: begin
            cnt_re    = 1'b1;
            cnt_raddr = held_rdata[CA_W-1:0];
            key_in    = held_rdata;
            state_in  = S_PWR;
         end
         S_PWR: begin
            // Slot is just below the running sum; lower the sum
            alu_req.op = ALU_DEC;
            alu_req.a  = cnt_rdata;
            cnt_we     = 1'b1;
            if (32'(alu_result) < MAX_ITEMS) begin
               sort_we = 1'b1;
            end
            walk_in = walk_dec;
            if (walk_ff == CNT_W'(1)) begin
               walk_in  = '0;
               state_in = S_EMIT;
            end else begin
               state_in = S_PKEY;
            end
         end
         S_EMIT: begin
            // Read one sorted word per cycle; the strobe lines up with the read data
            sort_re  = 1'b1;
            valid_in = 1'b1;
            final_in = (walk_inc == held_ff);
            ovf_in   = drop_ff;
            walk_in  = walk_inc;
            if (walk_inc == held_ff) begin
               ptr_in   = '0;
               state_in = S_CLEAR;
            end
         end
         default: begin
            ptr_in   = '0;
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ptr_ff   <= '0;
         pend_ff  <= 1'b0;
         held_ff  <= '0;
         drop_ff  <= 1'b0;
         valid_ff <= 1'b0;
         final_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         pend_ff  <= pend_in;
         held_ff  <= held_in;
         drop_ff  <= drop_in;
         valid_ff <= valid_in;
         final_ff <= final_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Payload and working registers need no reset
   always_ff @(posedge clock) begin
      waddr_ff <= waddr_in;
      acc_ff   <= acc_in;
      last_ff  <= last_in;
      take_ff  <= take_in;
      key_ff   <= key_in;
      walk_ff  <= walk_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_sorted_key    = sort_rdata;
   assign rsp_final_key     = final_ff;
   assign rsp_overflow_seen = ovf_ff;

endmodule

>>> src/csort_port_checker.sv
module csort_port_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_final_key
);

   // Reset starts the clear pass
   a_reset_busy: assert property (@(posedge clock) reset |=> busy && !rsp_valid)
      else $error("block not busy after reset");

   // Every accepted word keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block idle right after accepting a word");

   // Results only come out while the block is busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word while idle");

   // Results of a set come back to back until the final one
   a_rsp_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_final_key) |=> rsp_valid)
      else $error("gap inside a result burst");

   // Nothing follows the final result directly
   a_final_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_key) |=> !rsp_valid)
      else $error("result word right after the final one");

endmodule

bind counting_sort_engine_top csort_port_checker u_port_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_final_key (rsp_final_key)
);

>>> bench/counting_sort_engine_top_test.sv
module counting_sort_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import csort_pkg::*;

   localparam int NUM_SORT_KEYS = 128;
   localparam int SET_CAPACITY  = 64;
   localparam int TARGET_WORDS  = 250;
   // Longest silent stretch: count pass, placement of a full set, clear pass and a long gap.
   localparam int IDLE_LIMIT    = 4000;
   // Drain time after the last sorted word: covers the clear pass that follows it.
   localparam int TAIL_CYCLES   = 200;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_key;
      logic             final_key;
      logic             overflow_seen;
   } sorted_word_type;

   // Counting sort predictor plus the queue of sorted words still to come.
   class sort_scoreboard;
      logic [COUNT_W-1:0] key_counts [NUM_SORT_KEYS];
      logic [KEY_W-1:0]   held_keys [SET_CAPACITY];
      logic [KEY_W-1:0]   sorted_store [SET_CAPACITY];
      int                 held_count;
      bit                 dropped_flag;
      sorted_word_type    expected_words [$];
      int                 errors;
      int                 sets_sorted;
      int                 overflow_sets;
      int                 words_checked;

      function new();
         clear_set();
      endfunction

      function void clear_set();
         foreach (key_counts[k]) key_counts[k] = '0;
         held_count   = 0;
         dropped_flag = 1'b0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // Take in one accepted key; on set end, sort and queue the sorted words.
      function void note_key(logic [KEY_W-1:0] key, logic last);
         logic [KEY_W-1:0]   held;
         logic [COUNT_W-1:0] pos;
         sorted_word_type    word;
         int                 k;
         int                 n;
         if (key < NUM_SORT_KEYS) begin
            if (held_count >= SET_CAPACITY) begin
               dropped_flag = 1'b1;
            end else begin
               held_keys[held_count] = key;
               held_count++;
               key_counts[key] = key_counts[key] + 1'b1;
            end
         end
         if (!last) return;
         for (k = 1; k < NUM_SORT_KEYS; k++) key_counts[k] = key_counts[k] + key_counts[k-1];
         for (n = held_count; n > 0; n--) begin
            held = held_keys[n-1];
            pos = key_counts[held] - 1'b1;
            key_counts[held] = pos;
            if (pos < SET_CAPACITY) sorted_store[pos] = held;
         end
         for (k = 0; k < held_count; k++) begin
            word.sorted_key    = sorted_store[k];
            word.final_key     = (k + 1 == held_count);
            word.overflow_seen = dropped_flag;
            expected_words.push_back(word);
         end
         sets_sorted++;
         if (dropped_flag) overflow_sets++;
         clear_set();
      endfunction

      function void check_result(sorted_word_type got);
         sorted_word_type want;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: unexpected sorted word: key %0d final %0b overflow %0b", $time,
                     got.sorted_key, got.final_key, got.overflow_seen);
            return;
         end
         want = expected_words.pop_front();
         words_checked++;
         if (got.sorted_key !== want.sorted_key) begin
            errors++;
            $display("%0t: sorted_key expected %0d actual %0d", $time,
                     want.sorted_key, got.sorted_key);
         end
         if (got.final_key !== want.final_key) begin
            errors++;
            $display("%0t: final_key expected %0b actual %0b", $time,
                     want.final_key, got.final_key);
         end
         if (got.overflow_seen !== want.overflow_seen) begin
            errors++;
            $display("%0t: overflow_seen expected %0b actual %0b", $time,
                     want.overflow_seen, got.overflow_seen);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [KEY_W-1:0] req_key_value = '0;
   logic             req_set_end = 1'b0;
   logic             rsp_valid;
   logic [KEY_W-1:0] rsp_sorted_key;
   logic             rsp_final_key;
   logic             rsp_overflow_seen;

   sort_scoreboard sb = new();
   int             words_sent;
   int             idle_cycles;

   counting_sort_engine_top #(
      .NUM_KEYS (NUM_SORT_KEYS),
      .MAX_ITEMS(SET_CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_key_value    (req_key_value),
      .req_set_end      (req_set_end),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_final_key    (rsp_final_key),
      .rsp_overflow_seen(rsp_overflow_seen)
   );

   always #10 clock = ~clock;

   // Check every sorted word in the cycle it is shown; the receiver never stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result('{rsp_sorted_key, rsp_final_key, rsp_overflow_seen});
      end
   end

   // Watchdog: count cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (!reset && ((start && !busy) || rsp_valid)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drive one key word and hold it until the block takes it.
   task automatic send_word(input logic [KEY_W-1:0] key, input logic last, input bit idle_ok);
      int gap;
      gap = idle_ok ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_key_value <= key;
      req_set_end   <= last;
      do @(posedge clock); while (busy);
      sb.note_key(key, last);
      words_sent++;
   endtask

   // Send a whole set; the final word carries set_end.
   task automatic send_set(input logic [KEY_W-1:0] keys [$], input bit idle_ok);
      foreach (keys[i]) send_word(keys[i], i == keys.size() - 1, idle_ok);
   endtask

   // Drop start and hold off until every sorted word has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [KEY_W-1:0] keys [$];
      logic [KEY_W-1:0] base;
      int               set_size;
      int               set_idx;
      int               r;
      bit               narrow;

      // Hold reset at the start; once it is released the block runs its clear pass with busy high.
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed sets: single smallest and largest keys, duplicates mixed with
      // the extremes, a reversed run, and a set with one key repeated.
      send_set('{7'd0}, 1'b0);
      send_set('{7'd127}, 1'b1);
      send_set('{7'd127, 7'd0, 7'd64, 7'd0, 7'd127, 7'd1, 7'd126}, 1'b1);
      send_set('{7'd100, 7'd80, 7'd60, 7'd40, 7'd20}, 1'b0);
      send_set('{7'd85, 7'd85, 7'd42}, 1'b1);
      drain_results();

      // Random sets: first one over capacity, then one exactly at capacity,
      // then mostly small sets with an occasional large or overflowing one.
      set_idx = 0;
      while (words_sent < TARGET_WORDS) begin
         r = $urandom_range(0, 19);
         if (set_idx == 0) set_size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
         else if (set_idx == 1) set_size = SET_CAPACITY;
         else if (r == 0) set_size = $urandom_range(SET_CAPACITY, SET_CAPACITY + 8);
         else if (r < 4) set_size = $urandom_range(13, SET_CAPACITY - 1);
         else set_size = $urandom_range(1, 12);

         // Narrow key windows force many duplicate keys.
         narrow = 1'($urandom_range(0, 1));
         base   = KEY_W'($urandom_range(0, NUM_SORT_KEYS - 8));
         keys.delete();
         repeat (set_size) begin
            if (narrow) keys.push_back(KEY_W'(base + $urandom_range(0, 7)));
            else keys.push_back(KEY_W'($urandom_range(0, NUM_SORT_KEYS - 1)));
         end

         // Every third set or so goes back to back with no idling.
         send_set(keys, $urandom_range(0, 2) != 0);
         if ($urandom_range(0, 3) == 0) drain_results();
         set_idx++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sorted %0d sets from %0d key words, %0d of them over capacity;",
               sb.sets_sorted, words_sent, sb.overflow_sets);
      $display("%0d sorted words checked, %0d mismatches.", sb.words_checked, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
